FILE: src/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants of the 3x3 Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int PIX_W     = 8;   // gray pixel and result width
  localparam int CFG_W     = 12;  // width of a configuration register
  localparam int CFG_IDX_W = 2;   // configuration register index width
  localparam int ROW_W     = 13;  // row counter, counts up to height+1
  localparam int SUM_W     = 10;  // one weighted column or row sum, and |G|
  localparam int MAG_W     = 11;  // |Gx| + |Gy|
  localparam int WORD_W    = 2 * PIX_W;  // line RAM word: {upper, lower}

  localparam int WIDTH_RESET  = 512;
  localparam int HEIGHT_RESET = 512;
  localparam int DIM_MIN      = 3;
  localparam int MAG_MAX      = 255;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Which window borders lie inside the frame.
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } tap_mask_t;

  // Control that travels with one item through the gradient stages.
  typedef struct packed {
    logic      emit;
    logic      frame_end;
    tap_mask_t mask;
  } item_ctl_t;

endpackage

FILE: src/sem_line_ram.sv
// ----------------------------------------------------------------------------
// Line RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module sem_line_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/sem_grad.sv
// ----------------------------------------------------------------------------
// Sobel window and gradient stage
// Holds the 3x3 window and forms the masked absolute gradients.
// ----------------------------------------------------------------------------
module sem_grad (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      col_valid,
  input  logic [sem_pkg::PIX_W-1:0] col_up,
  input  logic [sem_pkg::PIX_W-1:0] col_mid,
  input  logic [sem_pkg::PIX_W-1:0] col_new,
  input  sem_pkg::item_ctl_t        ctl_in,
  output logic                      res_valid,
  output logic                      res_frame_end,
  output logic [sem_pkg::SUM_W-1:0] abs_gx,
  output logic [sem_pkg::SUM_W-1:0] abs_gy
);

  logic [sem_pkg::PIX_W-1:0] win_r [3][3];
  logic                      s2_valid_r;
  sem_pkg::item_ctl_t        s2_ctl_r;
  logic [sem_pkg::PIX_W-1:0] tap [3][3];
  logic [sem_pkg::SUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [sem_pkg::SUM_W-1:0] abs_gx_nxt, abs_gy_nxt;
  logic                      s3_valid_r;
  logic                      s3_emit_r;
  logic                      s3_fe_r;
  logic [sem_pkg::SUM_W-1:0] abs_gx_r, abs_gy_r;

  // Window: the newest column enters on the right.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (en && col_valid) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= col_up;
      win_r[1][2] <= col_mid;
      win_r[2][2] <= col_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= col_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl_r <= ctl_in;
    end
  end

  // Taps outside the frame read as zero.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && !s2_ctl_r.mask.top_ok) || (r == 2 && !s2_ctl_r.mask.bot_ok) ||
            (c == 0 && !s2_ctl_r.mask.left_ok) || (c == 2 && !s2_ctl_r.mask.right_ok)) begin
          tap[r][c] = '0;
        end else begin
          tap[r][c] = win_r[r][c];
        end
      end
    end
  end

  always_comb begin
    gx_pos = sem_pkg::SUM_W'(tap[0][2]) + {1'b0, tap[1][2], 1'b0} + sem_pkg::SUM_W'(tap[2][2]);
    gx_neg = sem_pkg::SUM_W'(tap[0][0]) + {1'b0, tap[1][0], 1'b0} + sem_pkg::SUM_W'(tap[2][0]);
    gy_pos = sem_pkg::SUM_W'(tap[0][0]) + {1'b0, tap[0][1], 1'b0} + sem_pkg::SUM_W'(tap[0][2]);
    gy_neg = sem_pkg::SUM_W'(tap[2][0]) + {1'b0, tap[2][1], 1'b0} + sem_pkg::SUM_W'(tap[2][2]);
    abs_gx_nxt = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    abs_gy_nxt = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_emit_r <= s2_ctl_r.emit;
      s3_fe_r   <= s2_ctl_r.frame_end;
      abs_gx_r  <= abs_gx_nxt;
      abs_gy_r  <= abs_gy_nxt;
    end
  end

  assign res_valid     = s3_valid_r && s3_emit_r;
  assign res_frame_end = s3_fe_r;
  assign abs_gx        = abs_gx_r;
  assign abs_gy        = abs_gy_r;

endmodule

FILE: src/sem_out.sv
// ----------------------------------------------------------------------------
// Magnitude and output stage
// Rounds and saturates the gradient sum; output register plus skid entry.
// ----------------------------------------------------------------------------
module sem_out (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      res_valid,
  input  logic                      res_frame_end,
  input  logic [sem_pkg::SUM_W-1:0] abs_gx,
  input  logic [sem_pkg::SUM_W-1:0] abs_gy,
  output logic                      en,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [sem_pkg::PIX_W-1:0] out_tdata,
  output logic                      out_tlast
);

  logic [sem_pkg::MAG_W-1:0] sum;
  logic [sem_pkg::SUM_W-1:0] half, half_rnd;
  logic [sem_pkg::PIX_W-1:0] mag;
  logic                      produce;
  logic                      out_v_r, skid_v_r;
  logic [sem_pkg::PIX_W-1:0] out_d_r, skid_d_r;
  logic                      out_l_r, skid_l_r;

  // Halve with round-half-to-even, then clip to the pixel range.
  always_comb begin
    sum      = sem_pkg::MAG_W'(abs_gx) + sem_pkg::MAG_W'(abs_gy);
    half     = sum[sem_pkg::MAG_W-1:1];
    half_rnd = half + sem_pkg::SUM_W'(sum[0] & half[0]);
    mag      = (half_rnd > sem_pkg::SUM_W'(sem_pkg::MAG_MAX)) ?
               sem_pkg::PIX_W'(sem_pkg::MAG_MAX) : half_rnd[sem_pkg::PIX_W-1:0];
  end

  assign en      = !skid_v_r;
  assign produce = en && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (produce) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (produce) begin
        skid_d_r <= mag;
        skid_l_r <= res_frame_end;
      end
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
      out_l_r <= skid_l_r;
    end else if (produce) begin
      out_d_r <= mag;
      out_l_r <= res_frame_end;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;

endmodule

FILE: src/sobel_edge_magnitude_3x3_top.sv
// ----------------------------------------------------------------------------
// The item image_width+1 items after a pixel releases its result through the
// RAM, window, gradient and output registers. Throughput: one transaction per
// cycle while the skid entry is empty, set by the single read-modify-write
// pass over the line RAM (one read port, one write port, one word per pixel).
// Reset (rst_n low at a clock edge): counters, window, pipeline and output
// clear, registers return to 512 x 512; the line RAM is not cleared.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// Sobel edge magnitude 3x3, top level
// Streams gray pixels in raster order and returns the halved, saturated
// L1 magnitude of the Sobel gradients, with zero padding at the borders.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream. tdata: [7:0] pixel. tuser: [0] flush.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sem_pkg::PIX_W-1:0]     in_tdata,
  input  logic                          in_tuser,
  // Result stream. tdata: [7:0] edge_value. tlast: frame_end.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sem_pkg::PIX_W-1:0]     out_tdata,
  output logic                          out_tlast,
  // Configuration writes: index 0 image_width, index 1 image_height.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data
);

  // AW addresses the line RAM; CW is wide enough for any column value and
  // for the width register, with one bit of headroom for compares.
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ((AW > sem_pkg::CFG_W) ? AW : sem_pkg::CFG_W) + 1;
  localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
  localparam int WIDTH_RST = (sem_pkg::WIDTH_RESET < MAX_WIDTH) ?
                             sem_pkg::WIDTH_RESET : MAX_WIDTH;

  // Configuration registers.
  logic [sem_pkg::CFG_W-1:0] width_r, height_r;
  logic [sem_pkg::CFG_W-1:0] cfg_clamped_w, cfg_clamped_h;

  // Raster counters.
  logic [AW-1:0]             col_r, col_nxt;
  logic [sem_pkg::ROW_W-1:0] row_r, row_nxt;

  // Acceptance stage signals.
  logic                      en;
  logic                      accept;
  logic [CW-1:0]             w_ext, col_ext, ci_c, ci_inc;
  logic [sem_pkg::ROW_W-1:0] h_ext;
  logic                      row_end;
  logic [sem_pkg::PIX_W-1:0] incoming;

  // RAM stage registers.
  logic                       p1_valid_r;
  logic [CW-1:0]              p1_col_r;
  logic [sem_pkg::ROW_W-1:0]  p1_row_r;
  logic [sem_pkg::PIX_W-1:0]  p1_inc_r;
  logic                       p1_fwd_r;
  logic [sem_pkg::WORD_W-1:0] p1_fwd_word_r;
  logic [sem_pkg::WORD_W-1:0] ram_rd_data, p1_word;
  logic [sem_pkg::PIX_W-1:0]  p1_up, p1_mid;

  // Center position of the result released by the item in the RAM stage.
  logic [CW-1:0]             ctr_c;
  logic [sem_pkg::ROW_W-1:0] ctr_r;
  sem_pkg::item_ctl_t        p1_ctl;

  // Gradient to output signals.
  logic                      res_valid, res_frame_end;
  logic [sem_pkg::SUM_W-1:0] abs_gx, abs_gy;

  // --------------------------------------------------------------------------
  // Configuration. Write only while the stream is idle; the block does not
  // enforce it; always ready. Values are clipped to the supported frame size.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_clamped_w = cfg_data;
    if (cfg_data < sem_pkg::CFG_W'(sem_pkg::DIM_MIN)) begin
      cfg_clamped_w = sem_pkg::CFG_W'(sem_pkg::DIM_MIN);
    end else if (CW'(cfg_data) > MAXW_C) begin
      cfg_clamped_w = MAXW_C[sem_pkg::CFG_W-1:0];
    end
    cfg_clamped_h = cfg_data;
    if (cfg_data < sem_pkg::CFG_W'(sem_pkg::DIM_MIN)) begin
      cfg_clamped_h = sem_pkg::CFG_W'(sem_pkg::DIM_MIN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sem_pkg::CFG_W'(WIDTH_RST);
      height_r <= sem_pkg::CFG_W'(sem_pkg::HEIGHT_RESET);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sem_pkg::REG_IMAGE_WIDTH: begin
          width_r <= cfg_clamped_w;
        end
        sem_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= cfg_clamped_h;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Acceptance stage. The whole pipeline moves on en, which only drops while
  // the skid entry of the output stage is occupied. The line RAM read for
  // the current column is issued on the accepting edge.
  // --------------------------------------------------------------------------
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  always_comb begin
    w_ext   = CW'(width_r);
    h_ext   = sem_pkg::ROW_W'(height_r);
    col_ext = CW'(col_r);
    // A width write that shrinks the row parks the column on the last one.
    ci_c    = (col_ext >= w_ext) ? w_ext - CW'(1) : col_ext;
    ci_inc  = ci_c + CW'(1);
    row_end = row_r >= h_ext + sem_pkg::ROW_W'(1);
    // Flush transactions and anything past the last row enter as zero.
    incoming = (!in_tuser && row_r < h_ext) ? in_tdata : '0;

    if (row_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (ci_inc >= w_ext) begin
      col_nxt = '0;
      row_nxt = row_r + sem_pkg::ROW_W'(1);
    end else begin
      col_nxt = ci_inc[AW-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // RAM stage. Each RAM word holds the column's two previous rows. The item
  // here rotates its word (lower moves up, the new pixel goes in below) and
  // writes it back on the edge it leaves. A following transaction that reads
  // the same column on that very edge would see the stale word, so the
  // rotated word is forwarded to it instead. This happens when a frame wraps
  // straight from column zero back to column zero.
  // --------------------------------------------------------------------------
  sem_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (sem_pkg::WORD_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (en && p1_valid_r),
    .wr_addr (p1_col_r[AW-1:0]),
    .wr_data ({p1_mid, p1_inc_r}),
    .rd_en   (accept),
    .rd_addr (ci_c[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign p1_word = p1_fwd_r ? p1_fwd_word_r : ram_rd_data;
  assign p1_up   = p1_word[sem_pkg::WORD_W-1:sem_pkg::PIX_W];
  assign p1_mid  = p1_word[sem_pkg::PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_col_r      <= ci_c;
      p1_row_r      <= row_r;
      p1_inc_r      <= incoming;
      p1_fwd_r      <= p1_valid_r && (p1_col_r == ci_c);
      p1_fwd_word_r <= {p1_mid, p1_inc_r};
    end
  end

  // The window center trails the input by one row and one column. At column
  // zero the center is the last pixel of the row two above.
  always_comb begin
    if (p1_col_r == '0) begin
      ctr_c = w_ext - CW'(1);
      ctr_r = p1_row_r - sem_pkg::ROW_W'(2);
    end else begin
      ctr_c = p1_col_r - CW'(1);
      ctr_r = p1_row_r - sem_pkg::ROW_W'(1);
    end
    p1_ctl.emit           = (p1_row_r >= sem_pkg::ROW_W'(2)) ||
                            (p1_row_r == sem_pkg::ROW_W'(1) && p1_col_r != '0);
    p1_ctl.mask.top_ok    = ctr_r != '0;
    p1_ctl.mask.bot_ok    = (ctr_r + sem_pkg::ROW_W'(1)) < h_ext;
    p1_ctl.mask.left_ok   = ctr_c != '0;
    p1_ctl.mask.right_ok  = (ctr_c + CW'(1)) < w_ext;
    p1_ctl.frame_end      = !p1_ctl.mask.bot_ok && (ctr_c + CW'(1) == w_ext);
  end

  // --------------------------------------------------------------------------
  // Window, gradients and output.
  // --------------------------------------------------------------------------
  sem_grad u_grad (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .col_valid     (p1_valid_r),
    .col_up        (p1_up),
    .col_mid       (p1_mid),
    .col_new       (p1_inc_r),
    .ctl_in        (p1_ctl),
    .res_valid     (res_valid),
    .res_frame_end (res_frame_end),
    .abs_gx        (abs_gx),
    .abs_gy        (abs_gy)
  );

  sem_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res_valid),
    .res_frame_end (res_frame_end),
    .abs_gx        (abs_gx),
    .abs_gy        (abs_gy),
    .en            (en),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

endmodule
